// File: rtl/csq_pkg.sv
// Shared types and constants for the counting semaphore wait queue.
package csq_pkg;

  localparam int COUNT_W = 8;
  localparam int SEM_W   = 5;
  localparam int PID_W   = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_FULL     = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [SEM_W-1:0]   sem_id;
    logic [PID_W-1:0]   caller_pid;
    logic [COUNT_W-1:0] init_count;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [PID_W-1:0]   released_pid;
    logic [COUNT_W-1:0] count_after;
  } res_t;

endpackage

// File: rtl/csq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module csq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/counting_semaphore_wait_queue.sv
// Counting semaphore table with a FIFO wait queue per semaphore.
//
// Command channel (cmd_valid/cmd_ready/cmd) takes one operation on one
// semaphore: init, lock or unlock. Result channel (res_valid/res_ready/res)
// returns exactly one transaction per command, in command order.
// The result is registered at the end of the lookup step, or after an extra
// pop step for an unlock that releases a waiter (read of the wait-entry RAM).
// A new command is taken only in the idle state, not before the previous one
// is through; the pace is set by the read-modify-write of the semaphore
// table RAM, whose registered read is followed by the write-back.
// A new command is accepted while a finished result still waits in the
// output register; if the receiver stalls, the next command waits in its
// lookup or pop step until the output register frees, and then commits.
// Reset clears the FSM, the output valid and the per-semaphore valid bits,
// so every semaphore reads as count 0 with an empty queue; no clearing pass
// is needed. The wait-entry RAM is never cleared.
module counting_semaphore_wait_queue #(
  parameter int NUM_SEMS    = 32,
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_PIDS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  csq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output csq_pkg::res_t res
);

  import csq_pkg::*;

  localparam int SEM_AW     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int HEAD_W     = $clog2(QUEUE_DEPTH);
  localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W      = LEN_W + 1;
  localparam int ENTRY_W    = COUNT_W + HEAD_W + LEN_W;
  localparam int WAIT_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int WAIT_AW    = $clog2(WAIT_DEPTH);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state, state_next;
  cmd_t   cur;
  logic [COUNT_W-1:0] pop_count;
  logic [NUM_SEMS-1:0] sem_valid;
  logic rd_valid;

  logic accept, can_out, res_load;
  res_t res_next;
  logic cmd_sem_ok, sem_ok, pid_ok;
  logic [SEM_AW-1:0] cmd_addr, cur_addr;

  logic               tab_rd_en, tab_wr_en;
  logic [ENTRY_W-1:0] tab_rd_data, tab_wr_data;
  logic               wait_rd_en, wait_wr_en;
  logic [WAIT_AW-1:0] wait_rd_addr, wait_wr_addr;
  logic [PID_W-1:0]   wait_rd_data;

  logic [COUNT_W-1:0] cnt, cnt_new;
  logic [HEAD_W-1:0]  head, head_new, tail;
  logic [LEN_W-1:0]   len, len_new;
  logic [SUM_W-1:0]   tail_sum, head_sum;
  logic tab_want, push_want, pop;

  assign cmd_addr   = SEM_AW'(cmd.sem_id);
  assign cur_addr   = SEM_AW'(cur.sem_id);
  assign cmd_sem_ok = 32'(cmd.sem_id) < NUM_SEMS;
  assign sem_ok     = 32'(cur.sem_id) < NUM_SEMS;
  assign pid_ok     = 32'(cur.caller_pid) < NUM_PIDS;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign can_out   = !res_valid || res_ready;
  assign tab_rd_en = accept && cmd_sem_ok;

  assign {cnt, head, len} = rd_valid ? tab_rd_data : '0;

  assign tail_sum = SUM_W'(head) + SUM_W'(len);
  assign tail     = (tail_sum >= SUM_WRAP) ? HEAD_W'(tail_sum - SUM_WRAP) : HEAD_W'(tail_sum);
  assign head_sum = SUM_W'(head) + SUM_W'(1);
  assign wait_wr_addr = WAIT_AW'(32'(cur_addr) * QUEUE_DEPTH + 32'(tail));
  assign wait_rd_addr = WAIT_AW'(32'(cur_addr) * QUEUE_DEPTH + 32'(head));
  assign tab_wr_data  = {cnt_new, head_new, len_new};

  always_comb begin
    cnt_new   = cnt;
    head_new  = head;
    len_new   = len;
    tab_want  = 1'b0;
    push_want = 1'b0;
    pop       = 1'b0;
    res_next  = '{status: ST_DONE, released_pid: '0, count_after: cnt};
    if (!sem_ok) begin
      res_next.status      = ST_INVALID;
      res_next.count_after = '0;
    end else begin
      case (cur.op)
        OP_INIT: begin
          cnt_new  = cur.init_count;
          head_new = '0;
          len_new  = '0;
          tab_want = 1'b1;
          res_next.count_after = cur.init_count;
        end
        OP_LOCK: begin
          if (!pid_ok) begin
            res_next.status = ST_INVALID;
          end else if (cnt != '0) begin
            cnt_new  = cnt - COUNT_W'(1);
            tab_want = 1'b1;
            res_next.count_after = cnt_new;
          end else if (len >= LEN_FULL) begin
            res_next.status = ST_FULL;
          end else begin
            len_new   = len + LEN_W'(1);
            tab_want  = 1'b1;
            push_want = 1'b1;
            res_next.status = ST_BLOCKED;
          end
        end
        OP_UNLOCK: begin
          if (len == '0) begin
            cnt_new  = (cnt != COUNT_MAX) ? cnt + COUNT_W'(1) : cnt;
            tab_want = 1'b1;
            res_next.count_after = cnt_new;
          end else begin
            head_new = (head_sum >= SUM_WRAP) ? HEAD_W'(head_sum - SUM_WRAP)
                                              : HEAD_W'(head_sum);
            len_new  = len - LEN_W'(1);
            tab_want = 1'b1;
            pop      = 1'b1;
          end
        end
        default: begin
          res_next.status = ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    tab_wr_en  = 1'b0;
    wait_wr_en = 1'b0;
    wait_rd_en = 1'b0;
    res_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (pop) begin
          tab_wr_en  = 1'b1;
          wait_rd_en = 1'b1;
          state_next = S_POP;
        end else if (can_out) begin
          tab_wr_en  = tab_want;
          wait_wr_en = push_want;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (can_out) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      sem_valid <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (tab_wr_en) begin
        sem_valid[cur_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cmd;
    end
    if (tab_rd_en) begin
      rd_valid <= sem_valid[cmd_addr];
    end
    if (state == S_LOOK) begin
      pop_count <= cnt;
    end
    if (res_load) begin
      if (state == S_POP) begin
        res <= '{status: ST_RELEASED, released_pid: wait_rd_data, count_after: pop_count};
      end else begin
        res <= res_next;
      end
    end
  end

  csq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_SEMS)
  ) u_sem_table (
    .clk     (clk),
    .wr_en   (tab_wr_en),
    .wr_addr (cur_addr),
    .wr_data (tab_wr_data),
    .rd_en   (tab_rd_en),
    .rd_addr (cmd_addr),
    .rd_data (tab_rd_data)
  );

  csq_ram #(
    .WIDTH(PID_W),
    .DEPTH(WAIT_DEPTH)
  ) u_wait_entries (
    .clk     (clk),
    .wr_en   (wait_wr_en),
    .wr_addr (wait_wr_addr),
    .wr_data (cur.caller_pid),
    .rd_en   (wait_rd_en),
    .rd_addr (wait_rd_addr),
    .rd_data (wait_rd_data)
  );

endmodule

// File: rtl/csq_chk.sv
// Port-level checks for the counting semaphore wait queue, bound to the top level.
module csq_chk (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input csq_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_ready,
  input csq_pkg::res_t res
);

  import csq_pkg::*;

  a_reset_clears_res: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result transaction changed");

  a_pid_only_on_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_RELEASED |-> res.released_pid == '0)
    else $error("released pid set without a release");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while previous one in lookup");

endmodule

bind counting_semaphore_wait_queue csq_chk u_csq_chk (.*);
